/* sv/ptc_pkg.sv */
// Shared constants, register codes and configuration types of the PID block.
package ptc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int GAIN_WIDTH_DEF   = 32;
   localparam int DRIVE_WIDTH      = 32;
   localparam int INTEG_WIDTH      = 32;
   localparam int LIMIT_WIDTH      = 31;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int FRAC_SHIFT       = 8;

   localparam logic [DRIVE_WIDTH-1:0] DRIVE_MAX_RESET = 32'h7FFF_FFFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PROP_GAIN    = 3'd0,
      REG_INTEG_GAIN   = 3'd1,
      REG_DERIV_GAIN   = 3'd2,
      REG_INTEG_LIMIT  = 3'd3,
      REG_DRIVE_MAX    = 3'd4,
      REG_DRIVE_MIN    = 3'd5,
      REG_DRIVE_OFFSET = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] integ_limit;
      logic [DRIVE_WIDTH-1:0] drive_max;
      logic [DRIVE_WIDTH-1:0] drive_min;
      logic [DRIVE_WIDTH-1:0] drive_offset;
   } drive_cfg_type;

endpackage

/* sv/ptc_csr.sv */
// Configuration registers: gains, integrator limit, drive bounds and offset.
module ptc_csr
   import ptc_pkg::*;
#(
   parameter int GAIN_WIDTH = GAIN_WIDTH_DEF,
   parameter int DATA_WIDTH = DRIVE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata,
   output logic [GAIN_WIDTH-1:0]      prop_gain,
   output logic [GAIN_WIDTH-1:0]      integ_gain,
   output logic [GAIN_WIDTH-1:0]      deriv_gain,
   output drive_cfg_type              drive_cfg
);

   logic [GAIN_WIDTH-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   drive_cfg_type         drive_cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff              <= '0;
         integ_gain_ff             <= '0;
         deriv_gain_ff             <= '0;
         drive_cfg_ff.integ_limit  <= '0;
         drive_cfg_ff.drive_max    <= DRIVE_MAX_RESET;
         drive_cfg_ff.drive_min    <= '0;
         drive_cfg_ff.drive_offset <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_PROP_GAIN:    prop_gain_ff  <= csr_wdata[GAIN_WIDTH-1:0];
            REG_INTEG_GAIN:   integ_gain_ff <= csr_wdata[GAIN_WIDTH-1:0];
            REG_DERIV_GAIN:   deriv_gain_ff <= csr_wdata[GAIN_WIDTH-1:0];
            REG_INTEG_LIMIT:  drive_cfg_ff.integ_limit  <= csr_wdata[LIMIT_WIDTH-1:0];
            REG_DRIVE_MAX:    drive_cfg_ff.drive_max    <= csr_wdata[DRIVE_WIDTH-1:0];
            REG_DRIVE_MIN:    drive_cfg_ff.drive_min    <= csr_wdata[DRIVE_WIDTH-1:0];
            REG_DRIVE_OFFSET: drive_cfg_ff.drive_offset <= csr_wdata[DRIVE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign prop_gain  = prop_gain_ff;
   assign integ_gain = integ_gain_ff;
   assign deriv_gain = deriv_gain_ff;
   assign drive_cfg  = drive_cfg_ff;

endmodule

/* sv/ptc_front.sv */
// Input stage: error terms, clamped trapezoidal integrator and sample history.
module ptc_front
   import ptc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [SAMPLE_WIDTH-1:0]       target,
   input  logic [SAMPLE_WIDTH-1:0]       sample,
   input  logic [LIMIT_WIDTH-1:0]        integ_limit,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_WIDTH:0]  err,
   output logic signed [SAMPLE_WIDTH:0]  diff,
   output logic signed [INTEG_WIDTH-1:0] integ
);

   localparam int EW = SAMPLE_WIDTH + 1;
   localparam int AW = ((EW > INTEG_WIDTH) ? EW : INTEG_WIDTH) + 1;

   logic                    valid_ff;
   logic [SAMPLE_WIDTH-1:0] last_ff;
   logic [INTEG_WIDTH-1:0]  integ_ff, integ_in;
   logic [EW-1:0]           err_ff, err_in, diff_ff, diff_in, prev_err, half;
   logic [EW:0]             pair;
   logic signed [AW-1:0]    acc, lim_pos, lim_neg, clip;
   logic                    accept;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      err_in   = {target[SAMPLE_WIDTH-1], target} - {sample[SAMPLE_WIDTH-1], sample};
      prev_err = {target[SAMPLE_WIDTH-1], target} - {last_ff[SAMPLE_WIDTH-1], last_ff};
      diff_in  = {last_ff[SAMPLE_WIDTH-1], last_ff} - {sample[SAMPLE_WIDTH-1], sample};
      pair     = {err_in[EW-1], err_in} + {prev_err[EW-1], prev_err};
      // dropping the low bit of a two's complement sum rounds toward minus infinity
      half     = pair[EW:1];
      acc      = $signed({{(AW-INTEG_WIDTH){integ_ff[INTEG_WIDTH-1]}}, integ_ff})
               + $signed({{(AW-EW){half[EW-1]}}, half});
      lim_pos  = $signed({{(AW-LIMIT_WIDTH){1'b0}}, integ_limit});
      lim_neg  = -lim_pos;
      if (acc > lim_pos) begin
         clip = lim_pos;
      end else if (acc < lim_neg) begin
         clip = lim_neg;
      end else begin
         clip = acc;
      end
      integ_in = clip[INTEG_WIDTH-1:0];
   end

   // integ_ff is both the integrator state and the payload of this stage:
   // it only changes on a new transfer, which also replaces the held item
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= '0;
         integ_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            last_ff  <= sample;
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
   end

   assign out_valid = valid_ff;
   assign err       = $signed(err_ff);
   assign diff      = $signed(diff_ff);
   assign integ     = $signed(integ_ff);

`ifndef ASSERT_OFF
   integ_within_limit: assert property (@(posedge clock) disable iff (reset)
      accept |=> ($signed(integ_ff) <= $signed({1'b0, integ_limit}))
              && ($signed(integ_ff) >= -$signed({1'b0, integ_limit})))
      else $error("integrator left its limit after a transfer");
   history_follows_sample: assert property (@(posedge clock) disable iff (reset)
      accept |=> last_ff == $past(sample))
      else $error("sample history not updated by transfer");
`endif

endmodule

/* sv/ptc_mac.sv */
// Gain products and their sum with the offset, two registered stages.
module ptc_mac
   import ptc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int GAIN_WIDTH   = GAIN_WIDTH_DEF,
   parameter int SUM_WIDTH    = GAIN_WIDTH + INTEG_WIDTH + SAMPLE_WIDTH + 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [SAMPLE_WIDTH:0]          err,
   input  logic signed [SAMPLE_WIDTH:0]          diff,
   input  logic signed [INTEG_WIDTH-1:0]         integ,
   input  logic [GAIN_WIDTH-1:0]                 prop_gain,
   input  logic [GAIN_WIDTH-1:0]                 integ_gain,
   input  logic [GAIN_WIDTH-1:0]                 deriv_gain,
   input  logic [DRIVE_WIDTH-1:0]                drive_offset,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [SUM_WIDTH-FRAC_SHIFT-1:0] sum
);

   localparam int EW = SAMPLE_WIDTH + 1;
   localparam int PW = GAIN_WIDTH + EW;
   localparam int IW = GAIN_WIDTH + INTEG_WIDTH;
   localparam int TW = SUM_WIDTH - FRAC_SHIFT;

   logic                 prod_valid_ff, sum_valid_ff, prod_ready, sum_ready;
   logic signed [PW-1:0] p_prop_ff, p_prop_in, p_der_ff, p_der_in;
   logic signed [IW-1:0] p_int_ff, p_int_in;
   logic signed [SUM_WIDTH-1:0] sum_full;
   logic [TW-1:0]        sum_ff, sum_in;

   assign sum_ready  = !sum_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign in_ready   = prod_ready;

   always_comb begin
      p_prop_in = $signed(prop_gain) * err;
      p_int_in  = $signed(integ_gain) * integ;
      p_der_in  = $signed(deriv_gain) * diff;
   end

   // terms carry 24 fraction bits (Q24.24 for the P and D products); the offset is aligned to the same point
   always_comb begin
      sum_full = $signed({{(SUM_WIDTH-PW){p_prop_ff[PW-1]}}, p_prop_ff})
               + $signed({{(SUM_WIDTH-IW){p_int_ff[IW-1]}}, p_int_ff})
               + $signed({{(SUM_WIDTH-PW){p_der_ff[PW-1]}}, p_der_ff})
               + $signed({{(SUM_WIDTH-DRIVE_WIDTH-FRAC_SHIFT){drive_offset[DRIVE_WIDTH-1]}},
                          drive_offset, {FRAC_SHIFT{1'b0}}});
      sum_in   = sum_full[SUM_WIDTH-1:FRAC_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && prod_ready) begin
         p_prop_ff <= p_prop_in;
         p_int_ff  <= p_int_in;
         p_der_ff  <= p_der_in;
      end
      if (prod_valid_ff && sum_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign sum       = $signed(sum_ff);

`ifndef ASSERT_OFF
   products_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && !sum_ready |=> prod_valid_ff && $stable(p_prop_ff)
                                   && $stable(p_int_ff) && $stable(p_der_ff))
      else $error("product stage lost its item while stalled");
`endif

endmodule

/* sv/ptc_drive.sv */
// Output stage: clamps the drive to its bounds and holds it for the result transfer.
module ptc_drive
   import ptc_pkg::*;
#(
   parameter int TRUNC_WIDTH = GAIN_WIDTH_DEF + INTEG_WIDTH + SAMPLE_WIDTH_DEF + 2 - FRAC_SHIFT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [TRUNC_WIDTH-1:0] sum,
   input  logic [DRIVE_WIDTH-1:0]        drive_max,
   input  logic [DRIVE_WIDTH-1:0]        drive_min,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [DRIVE_WIDTH-1:0]        rsp_tdata
);

   logic                          valid_ff;
   logic [DRIVE_WIDTH-1:0]        data_ff, data_in;
   logic signed [TRUNC_WIDTH-1:0] max_ext, min_ext, capped, raised;

   assign in_ready = !valid_ff || rsp_tready;

   // upper bound first, then lower bound, so min wins when the bounds cross
   always_comb begin
      max_ext = $signed({{(TRUNC_WIDTH-DRIVE_WIDTH){drive_max[DRIVE_WIDTH-1]}}, drive_max});
      min_ext = $signed({{(TRUNC_WIDTH-DRIVE_WIDTH){drive_min[DRIVE_WIDTH-1]}}, drive_min});
      capped  = (sum > max_ext) ? max_ext : sum;
      raised  = (capped < min_ext) ? min_ext : capped;
      data_in = raised[DRIVE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

`ifndef ASSERT_OFF
   drive_within_bounds: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ($signed(data_ff) >= $signed(drive_min))
                && (($signed(data_ff) <= $signed(drive_max)) || (data_ff == drive_min)))
      else $error("drive outside its bounds");
`endif

endmodule

/* sv/pid_trapezoid_clamped.sv */
// Top level of the PID controller with clamped trapezoidal integrator.
//
//  port group  dir  transfer when               payload
//  req_*       in   req_tvalid & req_tready     tdata: target, sample (Q8.8)
//  rsp_*       out  rsp_tvalid & rsp_tready     tdata: drive (Q16.16)
//  csr_*       in   csr_valid & csr_ready       csr_index, csr_wdata
//
// One item per cycle sustained while the rsp side accepts; after the request transfer an item
// passes the input/integrator register, product register, sum register and clamped output register,
// and rsp_tvalid rises once it is held in the last of these.
// The integrator and sample history update in the input stage, so back-to-back items
// see each other's state with no bubble. Reset clears the pipeline, the state and the
// registers (drive_max to the largest positive value). A stalled rsp side fills the
// four stages, after which req_tready drops; csr_ready is always high.
module pid_trapezoid_clamped
   import ptc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int GAIN_WIDTH   = GAIN_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // fields from bit 0: target, sample, zero fill
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // fields from bit 0: drive
   output logic [DRIVE_WIDTH-1:0]     rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [((GAIN_WIDTH > DRIVE_WIDTH) ? GAIN_WIDTH : DRIVE_WIDTH)-1:0] csr_wdata
);

   localparam int CSR_DATA_WIDTH = (GAIN_WIDTH > DRIVE_WIDTH) ? GAIN_WIDTH : DRIVE_WIDTH;
   localparam int OPER_WIDTH     = (SAMPLE_WIDTH + 1 > INTEG_WIDTH) ? SAMPLE_WIDTH + 1
                                                                    : INTEG_WIDTH;
   localparam int SUM_WIDTH      = GAIN_WIDTH + OPER_WIDTH + 2;
   localparam int TRUNC_WIDTH    = SUM_WIDTH - FRAC_SHIFT;

   logic [GAIN_WIDTH-1:0]          prop_gain, integ_gain, deriv_gain;
   drive_cfg_type                  drive_cfg;
   logic                           front_valid, mac_ready, mac_valid, drive_ready;
   logic signed [SAMPLE_WIDTH:0]   err, diff;
   logic signed [INTEG_WIDTH-1:0]  integ;
   logic signed [TRUNC_WIDTH-1:0]  sum;

   ptc_csr #(
      .GAIN_WIDTH (GAIN_WIDTH),
      .DATA_WIDTH (CSR_DATA_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .prop_gain  (prop_gain),
      .integ_gain (integ_gain),
      .deriv_gain (deriv_gain),
      .drive_cfg  (drive_cfg)
   );

   ptc_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .target      (req_tdata[SAMPLE_WIDTH-1:0]),
      .sample      (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .integ_limit (drive_cfg.integ_limit),
      .out_valid   (front_valid),
      .out_ready   (mac_ready),
      .err         (err),
      .diff        (diff),
      .integ       (integ)
   );

   ptc_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .GAIN_WIDTH   (GAIN_WIDTH),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (front_valid),
      .in_ready     (mac_ready),
      .err          (err),
      .diff         (diff),
      .integ        (integ),
      .prop_gain    (prop_gain),
      .integ_gain   (integ_gain),
      .deriv_gain   (deriv_gain),
      .drive_offset (drive_cfg.drive_offset),
      .out_valid    (mac_valid),
      .out_ready    (drive_ready),
      .sum          (sum)
   );

   ptc_drive #(
      .TRUNC_WIDTH (TRUNC_WIDTH)
   ) u_drive (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mac_valid),
      .in_ready   (drive_ready),
      .sum        (sum),
      .drive_max  (drive_cfg.drive_max),
      .drive_min  (drive_cfg.drive_min),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* test/drive_checker.sv */
// Checker for the PID block: mirrors register writes, predicts each drive value, compares.
module drive_checker
   import ptc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [2*SAMPLE_WIDTH_DEF-1:0] req_tdata,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [DRIVE_WIDTH-1:0]       rsp_tdata,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [DRIVE_WIDTH-1:0]       csr_wdata,
   output int                           fail_count,
   output int                           pending
);

   // controller state and register mirror
   logic signed [SAMPLE_WIDTH_DEF-1:0] prev_sample;
   logic signed [INTEG_WIDTH-1:0]      integ_acc;
   logic signed [GAIN_WIDTH_DEF-1:0]   kp, ki, kd;
   logic [LIMIT_WIDTH-1:0]             integ_bound;
   logic signed [DRIVE_WIDTH-1:0]      drv_hi, drv_lo, drv_bias;

   logic [DRIVE_WIDTH-1:0] drive_expected [$];
   int mismatch_total = 0;

   assign fail_count = mismatch_total;

   task automatic report_mismatch(input string what, input logic [DRIVE_WIDTH-1:0] want,
                                  input logic [DRIVE_WIDTH-1:0] got);
      $display("drive check: %s at %0t, expected %h got %h", what, $time, want, got);
      mismatch_total++;
   endtask

   // one controller step; updates the integrator and sample history
   function automatic logic [DRIVE_WIDTH-1:0] step_drive(
      input logic signed [SAMPLE_WIDTH_DEF-1:0] tgt,
      input logic signed [SAMPLE_WIDTH_DEF-1:0] smp);
      longint err, prev_err, acc, bound, total;
      err      = longint'(tgt) - longint'(smp);
      prev_err = longint'(tgt) - longint'(prev_sample);
      bound    = longint'(integ_bound);
      // half step floors toward minus infinity
      acc = longint'(integ_acc) + ((err + prev_err) >>> 1);
      if (acc > bound)
         acc = bound;
      else if (acc < -bound)
         acc = -bound;
      integ_acc = acc[INTEG_WIDTH-1:0];
      total = longint'(kp) * err + longint'(ki) * acc
            + longint'(kd) * (longint'(prev_sample) - longint'(smp))
            + (longint'(drv_bias) <<< FRAC_SHIFT);
      total = total >>> FRAC_SHIFT;
      if (total > longint'(drv_hi))
         total = longint'(drv_hi);
      if (total < longint'(drv_lo))
         total = longint'(drv_lo);
      prev_sample = smp;
      return total[DRIVE_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         prev_sample = '0;
         integ_acc   = '0;
         kp          = '0;
         ki          = '0;
         kd          = '0;
         integ_bound = '0;
         drv_hi      = DRIVE_MAX_RESET;
         drv_lo      = '0;
         drv_bias    = '0;
         drive_expected.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_PROP_GAIN:    kp = csr_wdata;
               REG_INTEG_GAIN:   ki = csr_wdata;
               REG_DERIV_GAIN:   kd = csr_wdata;
               REG_INTEG_LIMIT:  integ_bound = csr_wdata[LIMIT_WIDTH-1:0];
               REG_DRIVE_MAX:    drv_hi = csr_wdata;
               REG_DRIVE_MIN:    drv_lo = csr_wdata;
               REG_DRIVE_OFFSET: drv_bias = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            drive_expected.push_back(step_drive(req_tdata[SAMPLE_WIDTH_DEF-1:0],
                                                req_tdata[2*SAMPLE_WIDTH_DEF-1:SAMPLE_WIDTH_DEF]));
         if (rsp_tvalid && rsp_tready) begin
            if (drive_expected.size() == 0)
               report_mismatch("unexpected transfer", '0, rsp_tdata);
            else if (drive_expected[0] !== rsp_tdata)
               report_mismatch("drive", drive_expected.pop_front(), rsp_tdata);
            else
               void'(drive_expected.pop_front());
         end
      end
      // settles after this edge, so readers at the edge see a stable value
      pending <= drive_expected.size();
   end

endmodule

/* test/tb_pid_trapezoid_clamped.sv */
// Testbench top for the PID block: clock, reset, stimulus, flow control and verdict.
module tb_pid_trapezoid_clamped;
   import ptc_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int BLOCK_ITEMS = 50;
   localparam int NUM_BLOCKS  = 13;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [2*SAMPLE_WIDTH_DEF-1:0] req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [DRIVE_WIDTH-1:0]       rsp_tdata;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [DRIVE_WIDTH-1:0]       csr_wdata = '0;

   int fail_count;
   int pending;
   int stall_cycles = 0;
   int send_idle_pct = 25;
   int recv_idle_pct = 46;

   logic [DRIVE_WIDTH-1:0] cfg_word [0:REG_DRIVE_OFFSET];

   pid_trapezoid_clamped dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   drive_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ends the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   // leaves req_tvalid high after the transfer; drain_pipe lowers it
   task automatic send_item(input logic [SAMPLE_WIDTH_DEF-1:0] tgt,
                            input logic [SAMPLE_WIDTH_DEF-1:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {smp, tgt};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic apply_config();
      reg_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= cfg_word[idx];
         do @(posedge clock); while (!csr_ready);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                             input logic [31:0] lim, input logic [31:0] hi,
                             input logic [31:0] lo, input logic [31:0] ofs);
      cfg_word[REG_PROP_GAIN]    = p;
      cfg_word[REG_INTEG_GAIN]   = i;
      cfg_word[REG_DERIV_GAIN]   = d;
      cfg_word[REG_INTEG_LIMIT]  = lim;
      cfg_word[REG_DRIVE_MAX]    = hi;
      cfg_word[REG_DRIVE_MIN]    = lo;
      cfg_word[REG_DRIVE_OFFSET] = ofs;
      drain_pipe();
      apply_config();
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(7))
         0:       return '0;
         1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2, 3:    return $urandom;
         default: return $urandom_range(32'h6_0000) - 32'h3_0000;   // about +/-3.0
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return $urandom_range(32'h400);
         4, 5:    return $urandom_range(32'hF_FFFF);
         default: return {1'b0, 31'($urandom)};
      endcase
   endfunction

   task automatic random_config();
      logic [31:0] a, b, hi, lo, ofs;
      a = $urandom;
      b = $urandom;
      hi = ($signed(a) > $signed(b)) ? a : b;
      lo = ($signed(a) > $signed(b)) ? b : a;
      case ($urandom_range(7))
         0: begin                   // wide open
            hi = 32'h7FFF_FFFF;
            lo = 32'h8000_0000;
         end
         1: begin                   // crossed bounds: the lower bound wins
            hi = lo;
            lo = ($signed(a) > $signed(b)) ? a : b;
         end
         default: ;
      endcase
      ofs = $urandom_range(3) == 0 ? 32'($urandom) : $urandom_range(32'h4_0000) - 32'h2_0000;
      set_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), hi, lo, ofs);
   endtask

   initial begin
      logic [SAMPLE_WIDTH_DEF-1:0] walk_tgt, walk_smp;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: zero gains, drive held in [0, max]
      send_item(16'h0100, 16'h0000);
      send_item(16'h8000, 16'h7FFF);

      // unity gains, small integrator bound, positive offset
      set_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0200,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345);
      send_item(16'h7FFF, 16'h8000);   // integrator hits the upper bound
      send_item(16'h8000, 16'h7FFF);   // and the lower one
      send_item(16'h0001, 16'h0000);   // odd half step
      send_item(16'hFFFF, 16'h0000);   // even negative half step
      send_item(16'h7FFF, 16'h7FFF);
      send_item(16'h8000, 16'h8000);
      send_item(16'h5555, 16'hAAAA);
      send_item(16'h7FFF, 16'h0000);
      send_item(16'h7FFF, 16'h0000);

      // bound lowered below the held sum: next step clamps to it
      set_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0010,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345);
      send_item(16'h0000, 16'h0000);

      // extreme gains and offset, full integrator range: drive saturates
      set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(16'h7FFF, 16'h8000);
      send_item(16'h8000, 16'h7FFF);
      send_item(16'h8000, 16'h8000);
      send_item(16'h7FFF, 16'h7FFF);
      set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_item(16'h7FFF, 16'h8000);
      send_item(16'h8000, 16'h7FFF);

      // lower bound above upper bound, integrator pinned at zero
      set_config(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000,
                 32'h0000_0100, 32'h0000_1000, 32'h0000_0000);
      send_item(16'h1234, 16'h4321);
      send_item(16'h8000, 16'h7FFF);

      for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
         random_config();
         if (blk == 5) begin
            send_idle_pct = 46;
            recv_idle_pct = 25;
         end else if (blk == 9) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         walk_tgt = 16'($urandom);
         walk_smp = 16'($urandom);
         repeat (BLOCK_ITEMS) begin
            if ($urandom_range(3) == 0)
               send_item(16'($urandom), 16'($urandom));
            else begin
               // measurement wanders near a slowly changing setpoint
               if ($urandom_range(15) == 0)
                  walk_tgt = 16'($urandom);
               walk_smp = walk_smp + 16'($urandom_range(64)) - 16'd32;
               send_item(walk_tgt, walk_smp);
            end
         end
      end

      drain_pipe();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
